// File: src/mvc_pkg.sv
// Shared types, codes and constants of the move-to-front scale key cache.
`default_nettype none
package mvc_pkg;

  // Table geometry and field widths
  localparam int TableDepth = 32;
  localparam int KeyW       = 16;
  localparam int StatusW    = 2;
  localparam int DepthOutW  = 5;
  localparam int EvictOutW  = 4;
  localparam int OccOutW    = 6;
  localparam int MinScaleW  = 16;
  localparam int LimitW     = 6;
  localparam int BatchW     = 4;

  // Result status codes
  localparam logic [StatusW-1:0] StHitCurrent = 2'd0;
  localparam logic [StatusW-1:0] StHitMoved   = 2'd1;
  localparam logic [StatusW-1:0] StMiss       = 2'd2;
  localparam logic [StatusW-1:0] StReject     = 2'd3;

  // Register indexes (byte address 4*index)
  localparam logic [1:0] RegMinScale  = 2'd0;
  localparam logic [1:0] RegFullLimit = 2'd1;
  localparam logic [1:0] RegEvictBat  = 2'd2;

  // Register reset values
  localparam logic [MinScaleW-1:0] MinScaleRst  = 16'd13;
  localparam logic [LimitW-1:0]    FullLimitRst = 6'd30;
  localparam logic [BatchW-1:0]    EvictBatRst  = 4'd8;

  typedef struct packed {
    logic [MinScaleW-1:0] min_scale;
    logic [LimitW-1:0]    full_limit;
    logic [BatchW-1:0]    evict_batch;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/mvc_cell.sv
// One cell of the key row: holds a key, compares it, shifts from its neighbor.
`default_nettype none
module mvc_cell #(
  parameter int KeyWidth = 16
) (
  input  wire logic                clk_i,
  input  wire logic                shift_i,
  input  wire logic [KeyWidth-1:0] prev_key_i,
  input  wire logic [KeyWidth-1:0] search_key_i,
  output logic      [KeyWidth-1:0] key_o,
  output logic                     match_o
);

  logic [KeyWidth-1:0] key_q;
  logic                match_q;

  // Take the neighbor's key on a shift, else hold
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= prev_key_i;
    end
  end

  // Register the compare against the search key
  always_ff @(posedge clk_i) begin
    match_q <= (key_q == search_key_i);
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

// File: src/mvc_cfg.sv
// APB register file: minimum scale, full limit and eviction batch.
`default_nettype none
module mvc_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output mvc_pkg::cfg_t    cfg_o
);
  import mvc_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_scale   <= MinScaleRst;
      cfg_q.full_limit  <= FullLimitRst;
      cfg_q.evict_batch <= EvictBatRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegMinScale:  cfg_q.min_scale   <= pwdata[MinScaleW-1:0];
        RegFullLimit: cfg_q.full_limit  <= pwdata[LimitW-1:0];
        RegEvictBat:  cfg_q.evict_batch <= pwdata[BatchW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      RegMinScale:  prdata = 32'(cfg_q.min_scale);
      RegFullLimit: prdata = 32'(cfg_q.full_limit);
      RegEvictBat:  prdata = 32'(cfg_q.evict_batch);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: src/mru_view_cache_with_batch_evict_core.sv
// Top level of the move-to-front scale key cache with batch eviction.
//
//  channel   dir  handshake                 content
//  s_axis    in   s_axis_tvalid/tready      request: scale_w, scale_h
//  m_axis    out  m_axis_tvalid/tready      result: status, depth, evicted, occupancy
//  apb       in   psel & penable & pwrite   min_scale, full_limit, evict_batch
//
// A request passes a compare state, which registers the compare of the key against
// every cell of the row, and an update state, which resolves the newest match and
// shifts the row. The next request is taken in the update state when the result
// register is free, so a request is never taken while one is being compared. A
// result waiting on m_axis_tready holds the row and the request in the update
// state. Reset empties the table at once; the keys themselves are not cleared.
`default_nettype none
module mru_view_cache_with_batch_evict_core #(
  parameter int Depth = mvc_pkg::TableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request: [15:0] scale_w, [31:16] scale_h
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // result: [1:0] status, [6:2] found_depth, [10:7] evicted_count,
  //         [16:11] occupancy, [23:17] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mvc_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int LimW = (CntW > LimitW) ? CntW : LimitW;
  localparam int ExtW = CntW + BatchW;
  localparam int PosW = IdxW + DepthOutW;
  localparam int OccW = CntW + OccOutW;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SCmp  = 2'd1;
  localparam logic [1:0] SUpd  = 2'd2;

  cfg_t cfg;

  mvc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [1:0]      state_q, state_d;
  logic [KeyW-1:0] key_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            top_cur_q, top_cur_d;
  logic            out_valid_q;
  logic [23:0]     out_data_q, out_data_d;

  logic            in_fire, out_free, upd_fire;
  logic [KeyW:0]   key_sum;

  logic [KeyW-1:0] cell_key [Depth];
  logic [Depth-1:0] match, vmask, hv, pre, first, shift;

  logic            reject, hit_cur, any_hit;
  logic [IdxW-1:0] pos;
  logic [PosW-1:0] pos_ext;
  logic [DepthOutW-1:0] depth_out;
  logic [LimW-1:0] limit;
  logic [BatchW-1:0] batch, drop;
  logic [CntW-1:0] cnt_after;
  logic [OccW-1:0] occ_ext;
  logic [StatusW-1:0] status;
  logic [EvictOutW-1:0] evicted;

  assign out_free      = !out_valid_q | m_axis_tready;
  assign upd_fire      = (state_q == SUpd) & out_free;
  assign s_axis_tready = (state_q == SIdle) | upd_fire;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign key_sum       = {1'b0, s_axis_tdata[15:0]} + {1'b0, s_axis_tdata[31:16]};

  // Row of key cells; cell 0 is the newest entry
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    mvc_cell #(.KeyWidth(KeyW)) u_cell (
      .clk_i        (clk_i),
      .shift_i      (shift[i]),
      .prev_key_i   ((i == 0) ? key_q : cell_key[(i == 0) ? 0 : i-1]),
      .search_key_i (key_q),
      .key_o        (cell_key[i]),
      .match_o      (match[i])
    );
  end

  // Find the newest live match with a log-depth prefix OR
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      vmask[i] = (CntW'(i) < cnt_q);
    end
    hv  = match & vmask;
    pre = hv << 1;
    for (int l = 0; l < IdxW; l++) begin
      pre = pre | (pre << (1 << l));
    end
    first = hv & ~pre;
    pos   = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first[i]) begin
        pos = pos | IdxW'(i);
      end
    end
  end

  // Decide the request outcome and the next table state
  always_comb begin
    reject   = key_q < cfg.min_scale;
    hit_cur  = top_cur_q && (cnt_q != '0) && match[0];
    any_hit  = |hv;
    pos_ext  = PosW'(pos);
    depth_out = (pos_ext > PosW'(31)) ? DepthOutW'(31) : pos_ext[DepthOutW-1:0];
    limit    = (LimW'(cfg.full_limit) < LimW'(Depth)) ? LimW'(cfg.full_limit)
                                                       : LimW'(Depth);
    batch    = (cfg.evict_batch == '0) ? BatchW'(1) : cfg.evict_batch;
    drop     = '0;
    if (LimW'(cnt_q) >= limit) begin
      drop = (ExtW'(batch) < ExtW'(cnt_q)) ? batch : cnt_q[BatchW-1:0];
    end
    cnt_after = cnt_q - CntW'(drop);
    shift     = '0;
    cnt_d     = cnt_q;
    top_cur_d = top_cur_q;
    status    = StMiss;
    evicted   = '0;
    if (reject) begin
      status    = StReject;
      top_cur_d = 1'b0;
    end else if (hit_cur) begin
      status = StHitCurrent;
    end else if (any_hit) begin
      status    = StHitMoved;
      shift     = ~pre;
      top_cur_d = 1'b1;
    end else begin
      status    = StMiss;
      shift     = '1;
      evicted   = drop;
      cnt_d     = (cnt_after < CntW'(Depth)) ? cnt_after + CntW'(1) : cnt_after;
      top_cur_d = 1'b1;
    end
    if (!upd_fire) begin
      shift     = '0;
      cnt_d     = cnt_q;
      top_cur_d = top_cur_q;
    end
    occ_ext    = OccW'(cnt_d);
    out_data_d = '0;
    out_data_d[1:0]   = status;
    out_data_d[6:2]   = (status == StHitMoved) ? depth_out : '0;
    out_data_d[10:7]  = evicted;
    out_data_d[16:11] = (occ_ext > OccW'(63)) ? OccOutW'(63) : occ_ext[OccOutW-1:0];
  end

  // Advance the request sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_fire) state_d = SCmp;
      SCmp:    state_d = SUpd;
      SUpd:    if (in_fire) state_d = SCmp;
               else if (upd_fire) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      top_cur_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      top_cur_q <= top_cur_d;
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the request key and the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= key_sum[KeyW:1];
    end
    if (upd_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Occupancy never exceeds the table
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("entry count above table depth");

  // A result appears only out of the update cycle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == SUpd))
    else $error("result without update");

  // Any key that is not rejected ends up in the newest cell
  a_top_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire && !reject |=> cell_key[0] == $past(key_q))
    else $error("newest cell does not hold the request key");

  // A request is never taken during the compare cycle
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SCmp |-> !s_axis_tready)
    else $error("request taken while comparing");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench of the move-to-front scale key cache with batch eviction.
module tb;
  import mvc_pkg::*;

  localparam int ClkHalf      = 5;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int RxHoldCycles = 300;

  typedef struct {
    logic [StatusW-1:0]   status;
    logic [DepthOutW-1:0] depth;
    logic [EvictOutW-1:0] evicted;
    logic [OccOutW-1:0]   occ;
  } lookup_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the key row, its occupancy and the registers
  logic [KeyW-1:0]      key_row [TableDepth];
  int                   key_cnt;
  bit                   top_cur;
  logic [MinScaleW-1:0] min_key;
  logic [LimitW-1:0]    lim_reg;
  logic [BatchW-1:0]    batch_reg;

  lookup_res_t     pending_q [$];
  logic [KeyW-1:0] key_pool [$];
  int              last_idx;
  int              fail_cnt     = 0;
  int              cycle_cnt    = 0;
  int              tx_idle_pct  = 0;
  int              rx_stall_pct = 0;
  int              rx_hold_left = 0;

  mru_view_cache_with_batch_evict_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Look up one key, update the shadow row and return the expected result
  function automatic lookup_res_t cache_lookup(input logic [15:0] w, input logic [15:0] h);
    lookup_res_t     r;
    logic [16:0]     sum;
    logic [KeyW-1:0] key;
    int              p;
    int              hit_pos;
    int              limit;
    int              batch;
    int              drop;
    sum       = {1'b0, w} + {1'b0, h};
    key       = sum[16:1];
    r.status  = StMiss;
    r.depth   = '0;
    r.evicted = '0;
    if (key < min_key) begin
      top_cur  = 1'b0;
      r.status = StReject;
    end else if (top_cur && key_cnt > 0 && key_row[key_cnt-1] == key) begin
      r.status = StHitCurrent;
    end else begin
      // search from the newest entry
      hit_pos = -1;
      p = key_cnt - 1;
      while (p >= 0 && hit_pos < 0) begin
        if (key_row[p] == key) hit_pos = p;
        p--;
      end
      if (hit_pos >= 0) begin
        for (p = hit_pos + 1; p < key_cnt; p++) key_row[p-1] = key_row[p];
        key_row[key_cnt-1] = key;
        r.status = StHitMoved;
        r.depth  = (key_cnt - 1 - hit_pos > 31) ? 5'd31 : 5'(key_cnt - 1 - hit_pos);
      end else begin
        limit = (lim_reg < TableDepth) ? int'(lim_reg) : TableDepth;
        drop  = 0;
        if (key_cnt >= limit) begin
          batch = (batch_reg == 0) ? 1 : int'(batch_reg);
          drop  = (batch < key_cnt) ? batch : key_cnt;
          for (p = drop; p < key_cnt; p++) key_row[p-drop] = key_row[p];
          key_cnt -= drop;
        end
        if (key_cnt < TableDepth) begin
          key_row[key_cnt] = key;
          key_cnt++;
        end
        r.evicted = 4'(drop);
      end
      top_cur = 1'b1;
    end
    r.occ = (key_cnt > 63) ? 6'd63 : 6'(key_cnt);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Check each accepted result
  always @(posedge clk_i) begin
    lookup_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", want.status, m_axis_tdata[1:0]);
        check_field("found_depth", want.depth, m_axis_tdata[6:2]);
        check_field("evicted_count", want.evicted, m_axis_tdata[10:7]);
        check_field("occupancy", want.occ, m_axis_tdata[16:11]);
      end
    end
  end

  // Drive the receiver: count down a long hold, else stall at random
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Offer one request, idling first at random, and record its expected result
  task automatic send_req(input logic [15:0] w, input logic [15:0] h);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(cache_lookup(w, h));
  endtask

  // Split a key into a random pair of scales whose average truncates to it
  task automatic send_key(input logic [15:0] key);
    int s;
    int lo;
    int hi;
    int w;
    int h;
    s = 2 * int'(key) + $urandom_range(1, 0);
    if (s > 131070) s = 131070;
    lo = (s > 65535) ? s - 65535 : 0;
    hi = (s < 65535) ? s : 65535;
    w  = $urandom_range(hi, lo);
    h  = s - w;
    send_req(w[15:0], h[15:0]);
  endtask

  // Mostly pooled keys for hits and evictions, plus rejects and raw noise
  task automatic send_random_req();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      last_idx = $urandom_range(key_pool.size() - 1, 0);
      send_key(key_pool[last_idx]);
    end else if (pick < 73) begin
      send_key(key_pool[last_idx]);
    end else if (pick < 83 && min_key > 0) begin
      send_key(16'($urandom_range(int'(min_key) - 1, 0)));
    end else begin
      send_req(16'($urandom), 16'($urandom));
    end
  endtask

  // Drop valid and wait until every expected result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup and access phases, then back to idle on the bus
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMinScale:  min_key   = val[MinScaleW-1:0];
      RegFullLimit: lim_reg   = val[LimitW-1:0];
      RegEvictBat:  batch_reg = val[BatchW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int min_s, input int lim, input int bat);
    drain_results();
    apb_write(RegMinScale, min_s);
    apb_write(RegFullLimit, lim);
    apb_write(RegEvictBat, bat);
  endtask

  task automatic build_pool(input int n);
    key_pool.delete();
    repeat (n) key_pool.push_back(16'($urandom_range(65535, int'(min_key))));
    last_idx = 0;
  endtask

  // Reset defaults: reject, miss, current hit, moved hit, field extremes
  task automatic test_basic_lookups();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_req(16'd12, 16'd13);
    send_req(16'd13, 16'd13);
    send_req(16'd12, 16'd14);
    send_req(16'hFFFF, 16'hFFFF);
    send_req(16'h0000, 16'h0000);
    // top entry no longer current after a reject: found by the search
    send_req(16'hFFFF, 16'hFFFF);
    send_req(16'd13, 16'd14);
    send_req(16'hFFFF, 16'h0000);
    send_req(16'h0000, 16'hFFFF);
  endtask

  // Zero limit with a batch above occupancy, then a zero batch at the low limit
  task automatic test_eviction_corners();
    set_config(13, 0, 15);
    send_key(16'h1234);
    set_config(13, 9, 0);
    for (int i = 0; i < 9; i++) send_key(16'h2000 + 16'(i * 256));
    send_key(16'h2000);
  endtask

  task automatic test_random_phase(input int n, input int tx_pct, input int rx_pct,
                                   input int pool_n, input int min_s, input int lim,
                                   input int bat);
    set_config(min_s, lim, bat);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    build_pool(pool_n);
    repeat (n) send_random_req();
  endtask

  // Hold off the receiver so the block fills and stalls, then pause the sender
  task automatic test_backpressure();
    set_config(100, 12, 5);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    build_pool(20);
    rx_hold_left = RxHoldCycles;
    repeat (40) send_random_req();
    drain_results();
    repeat (20) send_random_req();
  endtask

  initial begin
    key_cnt   = 0;
    top_cur   = 1'b0;
    min_key   = MinScaleRst;
    lim_reg   = FullLimitRst;
    batch_reg = EvictBatRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_lookups();
    test_eviction_corners();
    test_random_phase(150, 0, 0, 36, 13, 30, 8);
    test_random_phase(150, 51, 0, 40, 0, 32, 1);
    test_random_phase(150, 0, 51, 48, 16'h4000, 63, 0);
    test_random_phase(150, 21, 21, 24, 16'h00FF, 9, 15);
    test_random_phase(30, 21, 21, 1, 16'hFFFF, 20, 3);
    test_backpressure();
    drain_results();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mvc_pkg.sv
src/mvc_cell.sv
src/mvc_cfg.sv
src/mru_view_cache_with_batch_evict_core.sv
tb/tb.sv
